// ===== src/assert_macros.svh =====
// assertion macros for the rtl files
// depends on nothing; every macro samples on a named clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/ksc_pkg.sv =====
// types, constants, keyword table and window match for keyword_spam_classifier
// depends on nothing
package ksc_pkg;

	localparam int NUM_KEYWORDS = 20;
	localparam int COUNT_BITS = 8;
	localparam int WINDOW_LEN = 8;

	localparam int KW_SLOTS = 32;
	localparam int KW_MAXLEN = 8;
	localparam int MATCH_W = 20;
	localparam int LIMB_W = 32;
	localparam int FACTOR_W = COUNT_BITS + 1;
	localparam int N_LIMBS = (NUM_KEYWORDS * FACTOR_W + LIMB_W - 1) / LIMB_W;
	localparam int PROD_W = N_LIMBS * LIMB_W;
	localparam int KW_IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
	localparam int LIMB_IDX_W = (N_LIMBS > 1) ? $clog2(N_LIMBS) : 1;

	typedef struct packed {
		logic       cmd;
		logic       train_is_spam;
		logic [7:0] char_code;
		logic       end_of_message;
	} ksc_in_t;

	typedef struct packed {
		logic               is_fraud;
		logic               score_spam;
		logic               has_link;
		logic [MATCH_W-1:0] matched_words;
	} ksc_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP
	} ksc_state_t;

	typedef logic [7:0] win_t [WINDOW_LEN];
	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [LIMB_W-1:0] limb_t;

	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_TRAIN = 1'b1;

	// text right justified: first letter in the highest used byte
	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_SLOTS] = '{
		64'("lottery"), 64'("free"), 64'("offer"), 64'("winner"), 64'("prize"),
		64'("urgent"), 64'("payment"), 64'("click"), 64'("reward"), 64'("claim"),
		64'("bank"), 64'("otp"), 64'("verify"), 64'("account"), 64'("link"),
		64'("meeting"), 64'("hello"), 64'("project"), 64'("thanks"), 64'("tomorrow"),
		64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
		64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
	};
	localparam int KW_LEN [KW_SLOTS] = '{
		7, 4, 5, 6, 5, 6, 7, 5, 6, 5, 4, 3, 6, 7, 4, 7, 5, 7, 6, 8,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
	};
	localparam logic [8*KW_MAXLEN-1:0] LINK_A_TEXT = 64'("http");
	localparam logic [8*KW_MAXLEN-1:0] LINK_B_TEXT = 64'("www");

	// only 'A'..'Z' are folded
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'h20) : c;
	endfunction

	// newest bytes of the window equal the word
	function automatic logic window_ends_with(input win_t w,
			input logic [8*KW_MAXLEN-1:0] text, input int len);
		logic hit;
		int pos;
		int sel;
		hit = (len != 0) && (len <= WINDOW_LEN);
		for (int k = 0; k < KW_MAXLEN; k++) begin
			if (k < len && len <= WINDOW_LEN) begin
				pos = WINDOW_LEN - len + k;
				sel = len - 1 - k;
				if (w[pos] != text[8*sel +: 8])
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

// ===== src/keyword_spam_classifier.sv =====
// keyword_spam_classifier: byte-serial keyword matcher with trained counts and
// limb-serial exact product compare; depends on ksc_pkg and assert_macros.svh
//
//  channel  | valid         | stall         | payload            | direction
//  ---------+---------------+---------------+--------------------+----------
//  char     | char_valid    | char_stall    | char_item (in_t)   | into block
//  verdict  | verdict_valid | verdict_stall | verdict (out_t)    | out of block
//
// a byte that does not close a classify message leaves the block idle and ready for the next byte;
// so does any train message. a classify message's last byte starts the shared 32 x 9 limb
// multiplier: an unmarked keyword is skipped, a marked keyword takes a pass over the N_LIMBS
// limbs of the spam product and then of the ham product, then the compare state follows.
// the verdict sits in an output register; the compare state waits while it is still stalled.
// reset clears counts, window, marks and control; there is no clearing pass.
`include "assert_macros.svh"

module keyword_spam_classifier import ksc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_stall,
	input  ksc_in_t  char_item,
	output logic     verdict_valid,
	input  logic     verdict_stall,
	output ksc_out_t verdict
);

	ksc_state_t state_q, state_d;

	win_t win_q, win_next;
	logic [NUM_KEYWORDS-1:0] seen_q, seen_next, words_q;
	logic link_q, link_next, msg_link_q;
	cnt_t spam_q [NUM_KEYWORDS];
	cnt_t ham_q [NUM_KEYWORDS];

	limb_t sp_q [N_LIMBS];
	limb_t hm_q [N_LIMBS];
	logic [KW_IDX_W-1:0] kidx_q;
	logic [LIMB_IDX_W-1:0] limb_q;
	logic phase_q;
	logic [FACTOR_W-1:0] carry_q;

	logic verdict_valid_q;
	ksc_out_t verdict_q;

	logic accept, last_limb, kw_marked, kw_done, out_free;
	logic [7:0] lc;
	logic [FACTOR_W-1:0] factor;
	limb_t limb_in;
	logic [LIMB_W+FACTOR_W-1:0] prod;
	logic [PROD_W-1:0] sp_flat, hm_flat;
	logic [MATCH_W-1:0] matched;

	assign accept = char_valid && !char_stall;
	assign char_stall = (state_q != ST_IDLE);
	assign verdict_valid = verdict_valid_q;
	assign verdict = verdict_q;
	assign out_free = !verdict_valid_q || !verdict_stall;

	// window shift and keyword marks for the incoming byte
	always_comb begin
		lc = fold_case(char_item.char_code);
		for (int i = 0; i + 1 < WINDOW_LEN; i++)
			win_next[i] = win_q[i+1];
		win_next[WINDOW_LEN-1] = lc;
		seen_next = seen_q;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (window_ends_with(win_next, KW_TEXT[i], KW_LEN[i]))
				seen_next[i] = 1'b1;
		end
		link_next = link_q || window_ends_with(win_next, LINK_A_TEXT, 4)
			|| window_ends_with(win_next, LINK_B_TEXT, 3);
	end

	// shared limb multiplier
	always_comb begin
		factor = {1'b0, (phase_q ? ham_q[kidx_q] : spam_q[kidx_q])} + FACTOR_W'(1);
		limb_in = phase_q ? hm_q[0] : sp_q[0];
		prod = (LIMB_W+FACTOR_W)'(limb_in) * (LIMB_W+FACTOR_W)'(factor)
			+ (LIMB_W+FACTOR_W)'(carry_q);
		last_limb = (limb_q == LIMB_IDX_W'(N_LIMBS - 1));
		kw_marked = words_q[kidx_q];
		kw_done = !kw_marked || (phase_q && last_limb);
		for (int i = 0; i < N_LIMBS; i++) begin
			sp_flat[LIMB_W*i +: LIMB_W] = sp_q[i];
			hm_flat[LIMB_W*i +: LIMB_W] = hm_q[i];
		end
		matched = '0;
		for (int i = 0; i < MATCH_W; i++) begin
			if (i < NUM_KEYWORDS)
				matched[i] = words_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && char_item.end_of_message && char_item.cmd == CMD_CLASSIFY)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (kw_done && kidx_q == KW_IDX_W'(NUM_KEYWORDS - 1))
					state_d = ST_CMP;
			end
			ST_CMP: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// message state and trained counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++)
				win_q[i] <= '0;
			seen_q <= '0;
			link_q <= 1'b0;
			for (int i = 0; i < NUM_KEYWORDS; i++) begin
				spam_q[i] <= '0;
				ham_q[i] <= '0;
			end
		end else if (accept) begin
			if (char_item.end_of_message) begin
				for (int i = 0; i < WINDOW_LEN; i++)
					win_q[i] <= '0;
				seen_q <= '0;
				link_q <= 1'b0;
				if (char_item.cmd == CMD_TRAIN) begin
					for (int i = 0; i < NUM_KEYWORDS; i++) begin
						if (seen_next[i]) begin
							if (char_item.train_is_spam && spam_q[i] != '1)
								spam_q[i] <= spam_q[i] + 1'b1;
							if (!char_item.train_is_spam && ham_q[i] != '1)
								ham_q[i] <= ham_q[i] + 1'b1;
						end
					end
				end
			end else begin
				win_q <= win_next;
				seen_q <= seen_next;
				link_q <= link_next;
			end
		end
	end

	// scoring sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kidx_q <= '0;
			limb_q <= '0;
			phase_q <= 1'b0;
			carry_q <= '0;
		end else if (state_q == ST_IDLE) begin
			kidx_q <= '0;
			limb_q <= '0;
			phase_q <= 1'b0;
			carry_q <= '0;
		end else if (state_q == ST_MUL && kw_marked) begin
			if (last_limb) begin
				limb_q <= '0;
				carry_q <= '0;
				phase_q <= !phase_q;
				if (phase_q && kidx_q != KW_IDX_W'(NUM_KEYWORDS - 1))
					kidx_q <= kidx_q + 1'b1;
			end else begin
				limb_q <= limb_q + 1'b1;
				carry_q <= prod[LIMB_W +: FACTOR_W];
			end
		end else if (state_q == ST_MUL && kidx_q != KW_IDX_W'(NUM_KEYWORDS - 1)) begin
			kidx_q <= kidx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			words_q <= seen_next;
			msg_link_q <= link_next;
			for (int i = 0; i < N_LIMBS; i++) begin
				sp_q[i] <= (i == 0) ? LIMB_W'(1) : '0;
				hm_q[i] <= (i == 0) ? LIMB_W'(1) : '0;
			end
		end else if (state_q == ST_MUL && kw_marked) begin
			// rotate the selected product one limb, new limb enters at the top
			if (phase_q) begin
				for (int i = 0; i + 1 < N_LIMBS; i++)
					hm_q[i] <= hm_q[i+1];
				hm_q[N_LIMBS-1] <= prod[LIMB_W-1:0];
			end else begin
				for (int i = 0; i + 1 < N_LIMBS; i++)
					sp_q[i] <= sp_q[i+1];
				sp_q[N_LIMBS-1] <= prod[LIMB_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (state_q == ST_CMP && out_free) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && out_free) begin
			verdict_q.score_spam <= (sp_flat > hm_flat);
			verdict_q.is_fraud <= (sp_flat > hm_flat) || msg_link_q;
			verdict_q.has_link <= msg_link_q;
			verdict_q.matched_words <= matched;
		end
	end

	`ASSERT_IMPL(a_busy_stalls, clk, arst_n, state_q != ST_IDLE, char_stall, "busy but not stalling")
	`ASSERT_IMPL(a_fraud_or, clk, arst_n, verdict_valid, verdict.is_fraud == (verdict.score_spam || verdict.has_link), "fraud flag mismatch")
	`ASSERT_CLK(a_limb_range, clk, arst_n, limb_q <= LIMB_IDX_W'(N_LIMBS - 1), "limb index out of range")

endmodule
